@@ hw/rtl/dwsp_pkg.sv @@
package dwsp_pkg;

    localparam int ACC_W  = 32;
    localparam int ERR_W  = 18;
    localparam int GAIN_W = 24;
    localparam int TGT_W  = 7;

    localparam logic [GAIN_W-1:0] FIX_P = 24'd2621440;
    localparam logic [GAIN_W-1:0] FIX_I = 24'd39;
    localparam logic [GAIN_W-1:0] FIX_D = 24'd655360;

    localparam logic [1:0] REG_GAIN_P = 2'd0;
    localparam logic [1:0] REG_GAIN_I = 2'd1;
    localparam logic [1:0] REG_GAIN_D = 2'd2;
    localparam logic [1:0] REG_MODE   = 2'd3;

    typedef struct packed {
        logic              start;
        logic [GAIN_W-1:0] p;
        logic [GAIN_W-1:0] i;
        logic [GAIN_W-1:0] d;
    } lane_ctl_t;

endpackage

@@ hw/rtl/dwsp_target.sv @@
// Base speed and left/right target split. Multi-cycle sequencer; the
// differential quotient is formed by a restoring divider, one bit per cycle.
module dwsp_target
    import dwsp_pkg::*;
#(
    parameter int IMAGE_ROWS = 60
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              dyn,
    input  logic signed [7:0] line_error,
    input  logic signed [7:0] line_error_prev,
    input  logic [5:0]        far_row,
    input  logic [5:0]        last_row,
    output logic              done,
    output logic [TGT_W-1:0]  left_target,
    output logic [TGT_W-1:0]  right_target
);

    typedef enum logic [2:0] {S_IDLE, S_BASE, S_SCALE, S_DIV, S_OUT} state_t;

    localparam int DW = 32;
    localparam int CW = $clog2(DW + 1);

    state_t             state_reg;
    logic [5:0]         prev_drop_reg;
    logic signed [15:0] tenths_reg;
    logic signed [7:0]  s_reg;
    logic signed [7:0]  e_reg;
    logic [5:0]         last_reg;
    logic               dyn_reg;
    logic [DW-1:0]      num_reg;
    logic               neg_reg;
    logic [DW-1:0]      den_reg;
    logic [DW-1:0]      quo_reg;
    logic [DW:0]        rem_reg;
    logic [CW-1:0]      cnt_reg;
    logic [TGT_W-1:0]   lt_reg, rt_reg;
    logic               done_reg;

    logic [5:0]         drop;
    logic [7:0]         ae;
    logic signed [15:0] tenths;
    logic [29:0]        tq;
    logic [10:0]        s_div;
    logic signed [7:0]  s_cl;
    logic signed [9:0]  dd;
    logic [19:0]        q;
    logic signed [31:0] prod;
    logic [DW:0]        rem_sh;
    logic signed [15:0] qv, sub_w, add_w;
    logic               rnz;
    logic signed [15:0] nl, nr;
    logic [27:0]        fql, fqr;
    logic signed [15:0] fl, fr;

    assign drop = (far_row < 6'd35) ? 6'd35 : ((far_row > 6'd55) ? 6'd55 : far_row);
    assign ae   = line_error[7] ? 8'(-line_error) : 8'(line_error);
    assign tenths = 16'(12 * $signed({10'd0, drop}))
                  + 16'(100 * ($signed({10'd0, drop}) - $signed({10'd0, prev_drop_reg})))
                  - 16'(3 * $signed({8'd0, ae}))
                  - 16'(10 * ($signed({{8{line_error[7]}}, line_error})
                              - $signed({{8{line_error_prev[7]}}, line_error_prev})));
    // tenths stays below 8711; x*52429 >> 19 is x/10 over that range
    assign tq    = 30'(tenths_reg[13:0]) * 30'd52429;
    assign s_div = tq[29:19];
    assign s_cl  = tenths_reg[15] ? 8'sd35
                 : ((s_div < 11'd35) ? 8'sd35 : ((s_div > 11'd55) ? 8'sd55 : 8'(s_div)));
    assign dd    = 10'(IMAGE_ROWS) - 10'(last_reg) - 10'd4;
    assign q     = (dd == 10'sd0) ? 20'd1 : 20'($signed(dd) * $signed(dd));
    assign prod  = 32'(30) * 32'($signed(e_reg)) * 32'($signed(s_reg));
    assign rem_sh = {rem_reg[DW-1:0], num_reg[DW-1]};
    // quotient beyond 255 always drives both sides into the clamp
    assign qv    = (|quo_reg[DW-1:8]) ? 16'sd255 : $signed({8'd0, quo_reg[7:0]});
    assign rnz   = |rem_reg;
    // side that moves down: floor of the exact value; side that moves up: s + quotient
    assign sub_w = 16'(s_reg) - qv - $signed({15'd0, rnz});
    assign add_w = 16'(s_reg) + qv;
    // fixed split: numerator below 16384, x*5243 >> 19 is x/100; negative ends up clamped
    assign nl    = 16'sd4000 - 16'sd72 * 16'(e_reg);
    assign nr    = 16'sd4000 + 16'sd72 * 16'(e_reg);
    assign fql   = 28'(nl[13:0]) * 28'd5243;
    assign fqr   = 28'(nr[13:0]) * 28'd5243;
    assign fl    = nl[15] ? 16'sd0 : $signed({7'd0, fql[27:19]});
    assign fr    = nr[15] ? 16'sd0 : $signed({7'd0, fqr[27:19]});

    function automatic logic [TGT_W-1:0] clamp(input logic signed [15:0] v,
                                               input logic signed [15:0] lo,
                                               input logic signed [15:0] hi);
        clamp = (v < lo) ? TGT_W'(lo) : ((v > hi) ? TGT_W'(hi) : TGT_W'(v));
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            prev_drop_reg <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        e_reg      <= line_error;
                        last_reg   <= last_row;
                        dyn_reg    <= dyn;
                        tenths_reg <= tenths;
                        if (dyn)
                            prev_drop_reg <= drop;
                        state_reg <= S_BASE;
                    end
                end
                S_BASE:
                begin
                    s_reg <= s_cl;
                    if (!dyn_reg)
                    begin
                        if (e_reg >= 8'sd10 || e_reg <= -8'sd10)
                        begin
                            lt_reg <= clamp(fl, 16'sd20, 16'sd80);
                            rt_reg <= clamp(fr, 16'sd20, 16'sd80);
                        end
                        else
                        begin
                            lt_reg <= TGT_W'(45);
                            rt_reg <= TGT_W'(45);
                        end
                        state_reg <= S_OUT;
                    end
                    else if (e_reg >= 8'sd10 || e_reg <= -8'sd10)
                        state_reg <= S_SCALE;
                    else
                    begin
                        lt_reg    <= TGT_W'(s_cl);
                        rt_reg    <= TGT_W'(s_cl);
                        state_reg <= S_OUT;
                    end
                end
                S_SCALE:
                begin
                    // |30*E*S| / q; sign and remainder applied per side after
                    neg_reg   <= prod[31];
                    num_reg   <= prod[31] ? 32'(-prod) : 32'(prod);
                    den_reg   <= 32'(q);
                    rem_reg   <= '0;
                    quo_reg   <= '0;
                    cnt_reg   <= CW'(DW);
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    num_reg <= {num_reg[DW-2:0], 1'b0};
                    if (rem_sh >= {1'b0, den_reg})
                    begin
                        rem_reg <= rem_sh - {1'b0, den_reg};
                        quo_reg <= {quo_reg[DW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_sh;
                        quo_reg <= {quo_reg[DW-2:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == CW'(1))
                        state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (dyn_reg && (e_reg >= 8'sd10 || e_reg <= -8'sd10))
                    begin
                        lt_reg <= clamp(neg_reg ? add_w : sub_w, 16'sd5, 16'sd110);
                        rt_reg <= clamp(neg_reg ? sub_w : add_w, 16'sd5, 16'sd110);
                    end
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign done         = done_reg;
    assign left_target  = lt_reg;
    assign right_target = rt_reg;

endmodule

@@ hw/rtl/dwsp_lane.sv @@
// One wheel: incremental PID on a saturating accumulator. Three products
// computed in states L_M0, L_M1 and L_M2 through one 27x18 multiplier.
module dwsp_lane
    import dwsp_pkg::*;
#(
    parameter int DUTY_LIMIT = 990
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  lane_ctl_t           ctl,
    input  logic [TGT_W-1:0]    target,
    input  logic signed [15:0]  measured,
    output logic                done,
    output logic [9:0]          duty
);

    typedef enum logic [2:0] {L_IDLE, L_M0, L_M1, L_M2, L_SUM, L_OUT} state_t;

    localparam int SW = 64;

    state_t               state_reg;
    logic signed [ERR_W-1:0] e0_reg, e1_reg, e2_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [SW-1:0]    sum_reg;
    logic [GAIN_W+1:0]       ka_reg, kb_reg, kd_reg;
    logic signed [SW-1:0]    mul_reg;
    logic [9:0]              duty_reg;
    logic                    done_reg;

    logic [GAIN_W+1:0]        mk;
    logic signed [ERR_W-1:0]  me;
    logic signed [GAIN_W+ERR_W+2:0] mprod;
    logic signed [SW-1:0]     quot;
    logic signed [SW-1:0]     sat;

    always_comb
    begin
        case (state_reg)
            L_M0:    begin mk = ka_reg; me = e0_reg; end
            L_M1:    begin mk = kb_reg; me = e1_reg; end
            default: begin mk = kd_reg; me = e2_reg; end
        endcase
    end

    assign mprod = $signed({1'b0, mk}) * me;

    // arithmetic shift rounds down; bias negatives to truncate toward zero
    assign quot = (sum_reg + (sum_reg[SW-1] ? SW'(65535) : SW'(0))) >>> 16;
    assign sat  = (quot > SW'(64'sh7FFFFFFF)) ? SW'(64'sh7FFFFFFF)
                : ((quot < -SW'(64'sh80000000)) ? -SW'(64'sh80000000) : quot);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            e0_reg    <= '0;
            e1_reg    <= '0;
            e2_reg    <= '0;
            acc_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                L_IDLE:
                begin
                    if (ctl.start)
                    begin
                        e2_reg <= e1_reg;
                        e1_reg <= e0_reg;
                        e0_reg <= ERR_W'($signed({1'b0, target})) - ERR_W'(measured);
                        ka_reg <= (GAIN_W+2)'(ctl.p) + (GAIN_W+2)'(ctl.i) + (GAIN_W+2)'(ctl.d);
                        kb_reg <= (GAIN_W+2)'(ctl.p) + ((GAIN_W+2)'(ctl.d) << 1);
                        kd_reg <= (GAIN_W+2)'(ctl.d);
                        sum_reg <= SW'(acc_reg) <<< 16;
                        state_reg <= L_M0;
                    end
                end
                L_M0, L_M1, L_M2:
                begin
                    mul_reg <= SW'(mprod);
                    if (state_reg == L_M1)
                        sum_reg <= sum_reg + mul_reg;
                    else if (state_reg == L_M2)
                        sum_reg <= sum_reg - mul_reg;
                    state_reg <= (state_reg == L_M0) ? L_M1
                               : ((state_reg == L_M1) ? L_M2 : L_SUM);
                end
                L_SUM:
                begin
                    sum_reg   <= sum_reg + mul_reg;
                    state_reg <= L_OUT;
                end
                L_OUT:
                begin
                    acc_reg  <= ACC_W'(sat);
                    duty_reg <= sat[SW-1] ? 10'd0
                              : ((sat > SW'(DUTY_LIMIT)) ? 10'(DUTY_LIMIT) : 10'(sat));
                    done_reg  <= 1'b1;
                    state_reg <= L_IDLE;
                end
                default: state_reg <= L_IDLE;
            endcase
        end
    end

    assign done = done_reg;
    assign duty = duty_reg;

endmodule

@@ hw/rtl/dual_wheel_speed_pid.sv @@
// Two-wheel speed controller. One request gives one result. Between the
// accepted request and m_tvalid in dynamic mode with a large line error,
// the target stage runs its 32-step divider for the differential split,
// then both wheel lanes run their PID update side by side, and the result
// moves through T_HOLD into the output register. Fixed mode or a small
// error skips the divider. One request is worked at a time; a new one is
// taken in the cycle after the result has been handed to the output
// register, and a result waits in T_HOLD only while the previous one is
// still unaccepted. Register map: 0x0 gain_p, 0x4 gain_i, 0x8 gain_d, 0xC
// dynamic_mode. The first fixed-mode request locks the gains to 40,
// 39/65536 and 10 until reset.
module dual_wheel_speed_pid
    import dwsp_pkg::*;
#(
    parameter int DUTY_LIMIT = 990,
    parameter int IMAGE_ROWS = 60
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // left_measured[15:0], right_measured[31:16], line_error[39:32],
    // line_error_prev[47:40], far_row[53:48], last_row[59:54]
    input  logic [63:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // left_duty[9:0], right_duty[19:10], left_target[26:20], right_target[33:27]
    output logic [39:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [1:0] {T_IDLE, T_TGT, T_PID, T_HOLD} state_t;

    state_t            state_reg;
    logic [GAIN_W-1:0] gp_reg, gi_reg, gd_reg;
    logic              dyn_reg;
    logic              latched_reg;
    logic [15:0]       lm_reg, rm_reg;
    logic              ovalid_reg;
    logic [39:0]       odata_reg;
    logic              tstart;
    logic              tdone, ldone, rdone;
    logic [TGT_W-1:0]  lt, rt;
    logic [9:0]        ld, rd;
    lane_ctl_t         ctl;
    logic              accept, cfg_wr;
    logic [1:0]        ridx;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;
    assign ridx     = paddr[3:2];
    assign s_tready = (state_reg == T_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign tstart   = accept;

    always_comb
    begin
        case (ridx)
            REG_GAIN_P: prdata = 32'(gp_reg);
            REG_GAIN_I: prdata = 32'(gi_reg);
            REG_GAIN_D: prdata = 32'(gd_reg);
            default:    prdata = 32'(dyn_reg);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gp_reg      <= 24'd4915200;
            gi_reg      <= 24'd39;
            gd_reg      <= 24'd589824;
            dyn_reg     <= 1'b1;
            latched_reg <= 1'b0;
            state_reg   <= T_IDLE;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                case (ridx)
                    REG_GAIN_P: gp_reg  <= pwdata[GAIN_W-1:0];
                    REG_GAIN_I: gi_reg  <= pwdata[GAIN_W-1:0];
                    REG_GAIN_D: gd_reg  <= pwdata[GAIN_W-1:0];
                    default:    dyn_reg <= pwdata[0];
                endcase
            end
            if (state_reg == T_HOLD && (!ovalid_reg || m_tready))
                ovalid_reg <= 1'b1;
            else if (m_tready)
                ovalid_reg <= 1'b0;
            case (state_reg)
                T_IDLE:
                begin
                    if (accept)
                    begin
                        lm_reg    <= s_tdata[15:0];
                        rm_reg    <= s_tdata[31:16];
                        if (!dyn_reg)
                            latched_reg <= 1'b1;
                        state_reg <= T_TGT;
                    end
                end
                T_TGT:
                    if (tdone)
                        state_reg <= T_PID;
                T_PID:
                    if (ldone)
                        state_reg <= T_HOLD;
                T_HOLD:
                begin
                    // lanes and targets hold their outputs until the next start
                    if (!ovalid_reg || m_tready)
                    begin
                        odata_reg <= {6'd0, rt, lt, rd, ld};
                        state_reg <= T_IDLE;
                    end
                end
                default: state_reg <= T_IDLE;
            endcase
        end
    end

    assign ctl.start = tdone;
    assign ctl.p     = latched_reg ? FIX_P : gp_reg;
    assign ctl.i     = latched_reg ? FIX_I : gi_reg;
    assign ctl.d     = latched_reg ? FIX_D : gd_reg;

    dwsp_target #(.IMAGE_ROWS(IMAGE_ROWS)) u_tgt (
        .clk(clk), .rst_n(rst_n), .start(tstart), .dyn(dyn_reg),
        .line_error(s_tdata[39:32]), .line_error_prev(s_tdata[47:40]),
        .far_row(s_tdata[53:48]), .last_row(s_tdata[59:54]),
        .done(tdone), .left_target(lt), .right_target(rt)
    );

    dwsp_lane #(.DUTY_LIMIT(DUTY_LIMIT)) u_left (
        .clk(clk), .rst_n(rst_n), .ctl(ctl), .target(lt), .measured(lm_reg),
        .done(ldone), .duty(ld)
    );

    dwsp_lane #(.DUTY_LIMIT(DUTY_LIMIT)) u_right (
        .clk(clk), .rst_n(rst_n), .ctl(ctl), .target(rt), .measured(rm_reg),
        .done(rdone), .duty(rd)
    );

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = odata_reg;

    a_lanes_sync: assert property (@(posedge clk) disable iff (!rst_n)
        ldone == rdone) else $error("wheel lanes out of step");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != T_IDLE |-> !s_tready) else $error("request taken while busy");
    a_done_in_pid: assert property (@(posedge clk) disable iff (!rst_n)
        ldone |-> state_reg == T_PID) else $error("lane done outside PID phase");
    a_latch_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        $past(latched_reg) |-> latched_reg) else $error("gain lock dropped");

endmodule
